// File: rtl/cwmf_pkg.sv
// Shared constants for the clipped window median filter.
package cwmf_pkg;

  localparam int unsigned CFG_ADDR_BITS = 4;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_HROWS  = 2'd2;
  localparam logic [1:0] REG_HCOLS  = 2'd3;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned ROW_BITS   = 13;

endpackage

// File: rtl/cwmf_rank.sv
// Serial rank counter: compares the candidate against the window one pixel per cycle while en is high.
module cwmf_rank #(
  parameter int unsigned PIXEL_BITS = 16,
  parameter int unsigned CNT_BITS   = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clr,
  input  logic                  en,
  input  logic [PIXEL_BITS-1:0] cand,
  input  logic [PIXEL_BITS-1:0] other,
  input  logic                  other_before,
  output logic [CNT_BITS-1:0]   less_cnt
);
  import cwmf_pkg::*;

  logic [CNT_BITS-1:0] less_r, less_nxt;
  logic                smaller;

  // Ties break by window order so that every pixel has a distinct rank.
  assign smaller  = (other < cand) || ((other == cand) && other_before);
  assign less_nxt = clr ? '0 : (en && smaller) ? less_r + 1'b1 : less_r;
  assign less_cnt = less_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      less_r <= '0;
    end else begin
      less_r <= less_nxt;
    end
  end
endmodule

// File: rtl/clipped_window_median_filter.sv
// Top level of the clipped window median filter with a line store and rank selection.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | in_tdata = pixel_value, in_tuser = cmd
//  out_    | out | out_tvalid/out_tready| out_tdata = median_twice, out_tlast = frame_last
//  cfg_    | in  | APB psel/penable     | four registers at byte addresses 0,4,8,12
//
// Each output ranks the window's candidate pixels in turn until both middles are known:
// after setup, each candidate is loaded from the line store and then ranked against every
// window pixel through its one read port, one compare per cycle.
// An input pixel may release up to hx+1 outputs.
// Reset is synchronous; the line store has no reset and is never read before written.
// in_tready drops while outputs are pending; one output register holds a result
// until out_tready takes it, and the work stalls behind it.
module clipped_window_median_filter #(
  parameter int unsigned MAX_WIDTH     = 1024,
  parameter int unsigned MAX_HALF_ROWS = 3,
  parameter int unsigned MAX_HALF_COLS = 3,
  parameter int unsigned PIXEL_BITS    = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]    in_tdata,   // [PIXEL_BITS-1:0] pixel_value
  input  logic                               in_tuser,   // [0] cmd
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [((PIXEL_BITS+8)/8)*8-1:0]    out_tdata,  // [PIXEL_BITS:0] median_twice
  output logic                               out_tlast,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [cwmf_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);
  import cwmf_pkg::*;

  localparam int unsigned RING   = 2*MAX_HALF_ROWS+1;
  localparam int unsigned COLB   = $clog2(MAX_WIDTH);
  localparam int unsigned WB     = $clog2(MAX_WIDTH+1);
  localparam int unsigned RINGB  = $clog2(RING);
  localparam int unsigned WINR   = 2*MAX_HALF_ROWS+1;
  localparam int unsigned WINC   = 2*MAX_HALF_COLS+1;
  localparam int unsigned NMAX   = WINR*WINC;
  localparam int unsigned CNTB   = $clog2(NMAX+1);
  localparam int unsigned IDXB   = $clog2(NMAX);
  localparam int unsigned ADDRB  = $clog2(RING*MAX_WIDTH);
  localparam int unsigned HYB    = $clog2(MAX_HALF_ROWS+1);
  localparam int unsigned HXB    = $clog2(MAX_HALF_COLS+1);
  localparam int unsigned ODW    = ((PIXEL_BITS+8)/8)*8;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_CAND = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_EVAL = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // configuration
  logic [10:0] width_r;
  logic [12:0] height_r;
  logic [1:0]  hrows_r, hcols_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_prdata = '0;
    case (cfg_paddr[CFG_ADDR_BITS-1:2])
      REG_WIDTH:  cfg_prdata = {21'd0, width_r};
      REG_HEIGHT: cfg_prdata = {19'd0, height_r};
      REG_HROWS:  cfg_prdata = {30'd0, hrows_r};
      REG_HCOLS:  cfg_prdata = {30'd0, hcols_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // effective (clamped) settings
  logic [WB-1:0]        w_eff;
  logic [ROW_BITS-1:0]  h_eff;
  logic [HYB-1:0]       hy_eff;
  logic [HXB-1:0]       hx_eff;

  always_comb begin
    if (width_r == '0) w_eff = WB'(1);
    else if (32'(width_r) > MAX_WIDTH) w_eff = WB'(MAX_WIDTH);
    else w_eff = WB'(width_r);
    if (height_r == '0) h_eff = ROW_BITS'(1);
    else if (32'(height_r) > MAX_HEIGHT) h_eff = ROW_BITS'(MAX_HEIGHT);
    else h_eff = height_r;
    hy_eff = (32'(hrows_r) > MAX_HALF_ROWS) ? HYB'(MAX_HALF_ROWS) : HYB'(hrows_r);
    hx_eff = (32'(hcols_r) > MAX_HALF_COLS) ? HXB'(MAX_HALF_COLS) : HXB'(hcols_r);
  end

  // positions; rows held one bit wider to reach height
  logic [ROW_BITS-1:0] in_row_r, out_row_r;
  logic [WB-1:0]       in_col_r, out_col_r;
  logic [ROW_BITS-1:0] wr_row_r;          // row of the last written pixel
  logic [WB-1:0]       wr_col_r;
  logic [RINGB-1:0]    in_slot_r;         // in_row mod RING
  logic [RINGB-1:0]    out_slot_r;        // out_row mod RING
  logic                pix_mode_r;        // job came from a pixel (keep releasing)

  logic [2:0] state_r;

  // window bounds for current output
  logic [ROW_BITS-1:0] top_r, bot_r;
  logic [WB-1:0]       left_r, right_r;
  logic [CNTB-1:0]     n_r;

  // candidate and scan iterators
  logic [ROW_BITS-1:0] cv_r;
  logic [WB-1:0]       cu_r, su_r;
  logic [RINGB-1:0]    cslot_r, sslot_r;
  logic [IDXB-1:0]     cidx_r, sidx_r;
  logic                scan_done_r;
  logic                rd_valid_r;        // read data holds a scan pixel
  logic [IDXB-1:0]     rd_idx_r;
  logic [PIXEL_BITS-1:0] cand_r;
  logic [PIXEL_BITS-1:0] lo_val_r;
  logic                lo_found_r;
  logic [PIXEL_BITS-1:0] hi_val_r;
  logic                hi_found_r;
  logic                cand_load_r;

  logic [PIXEL_BITS:0] res_r;
  logic                last_r;
  logic                ovalid_r;

  // line store
  logic [PIXEL_BITS-1:0] mem [RING*MAX_WIDTH];
  logic [PIXEL_BITS-1:0] rd_data_r;
  logic [ADDRB-1:0]      rd_addr;
  logic                  mem_we;
  logic [ADDRB-1:0]      wr_addr;

  function automatic logic [ADDRB-1:0] addr_of(input logic [RINGB-1:0] s,
                                               input logic [WB-1:0] c);
    addr_of = ADDRB'(s) * ADDRB'(MAX_WIDTH) + ADDRB'(c[COLB-1:0]);
  endfunction

  function automatic logic [RINGB-1:0] slot_inc(input logic [RINGB-1:0] s);
    slot_inc = (32'(s) == RING-1) ? '0 : s + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= in_tdata[PIXEL_BITS-1:0];
    rd_data_r <= mem[rd_addr];
  end

  // ranking unit
  logic [CNTB-1:0] less_cnt;
  logic            rank_clr, rank_en;
  cwmf_rank #(.PIXEL_BITS(PIXEL_BITS), .CNT_BITS(CNTB)) u_rank (
    .clk, .rst_n, .clr(rank_clr), .en(rank_en), .cand(cand_r), .other(rd_data_r),
    .other_before(rd_idx_r < cidx_r), .less_cnt
  );

  // readiness of the next output
  logic [ROW_BITS+1:0] rc_full, xr;
  logic [WB-1:0]       rc;
  logic                out_ready_now;
  always_comb begin
    xr = (ROW_BITS+2)'(out_col_r) + (ROW_BITS+2)'(hx_eff);
    rc_full = (ROW_BITS+2)'(w_eff) - 1'b1;
    rc = (xr < rc_full) ? WB'(xr) : WB'(rc_full);
    out_ready_now = ((ROW_BITS+2)'(out_row_r) + (ROW_BITS+2)'(hy_eff) < (ROW_BITS+2)'(wr_row_r))
      || (((ROW_BITS+2)'(out_row_r) + (ROW_BITS+2)'(hy_eff) == (ROW_BITS+2)'(wr_row_r))
          && rc <= wr_col_r);
  end

  logic in_acc;
  assign in_tready = (state_r == S_IDLE) && !ovalid_r;
  assign in_acc    = in_tvalid && in_tready;

  logic pix_ok;
  assign pix_ok = (in_tuser == CMD_PIXEL) && (in_row_r < h_eff) && (in_col_r < w_eff);
  assign mem_we  = in_acc && pix_ok;
  assign wr_addr = addr_of(in_slot_r, in_col_r);

  // target ranks: lower middle (n-1)/2 and upper middle n/2
  logic [CNTB-1:0] k_lo, k_hi;
  assign k_hi = n_r >> 1;
  assign k_lo = (n_r - 1'b1) >> 1;

  // both middles known once the current candidate is counted in
  logic                  got_lo, got_hi;
  logic [PIXEL_BITS-1:0] lo_v, hi_v;
  assign got_lo = lo_found_r || (less_cnt == k_lo);
  assign got_hi = hi_found_r || (less_cnt == k_hi);
  assign lo_v   = (less_cnt == k_lo) ? cand_r : lo_val_r;
  assign hi_v   = (less_cnt == k_hi) ? cand_r : hi_val_r;

  always_comb begin
    rd_addr  = addr_of(sslot_r, su_r);
    if (state_r == S_CAND) rd_addr = addr_of(cslot_r, cu_r);
    rank_clr = (state_r == S_CAND);
    rank_en  = (state_r == S_SCAN || state_r == S_EVAL) && rd_valid_r;
  end

  logic last_now;
  assign last_now = (out_row_r == h_eff - 1'b1) && (out_col_r == w_eff - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 11'd1024; height_r <= 13'd1024; hrows_r <= 2'd1; hcols_r <= 2'd1;
      in_row_r <= '0; in_col_r <= '0; out_row_r <= '0; out_col_r <= '0;
      in_slot_r <= '0; out_slot_r <= '0; wr_row_r <= '0; wr_col_r <= '0;
      state_r <= S_IDLE; ovalid_r <= 1'b0; rd_valid_r <= 1'b0; pix_mode_r <= 1'b0;
      cand_load_r <= 1'b0; lo_found_r <= 1'b0; hi_found_r <= 1'b0; scan_done_r <= 1'b0;
    end else begin
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      if (cfg_wr) begin
        // write and restart the frame
        case (cfg_paddr[CFG_ADDR_BITS-1:2])
          REG_WIDTH:  width_r  <= cfg_pwdata[10:0];
          REG_HEIGHT: height_r <= cfg_pwdata[12:0];
          REG_HROWS:  hrows_r  <= cfg_pwdata[1:0];
          REG_HCOLS:  hcols_r  <= cfg_pwdata[1:0];
          default: ;
        endcase
        in_row_r <= '0; in_col_r <= '0; out_row_r <= '0; out_col_r <= '0;
        in_slot_r <= '0; out_slot_r <= '0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_tuser == CMD_FLUSH) begin
              if (in_row_r >= h_eff && out_row_r < h_eff) begin
                pix_mode_r <= 1'b0;
                state_r <= S_CHK;
                wr_row_r <= h_eff; wr_col_r <= '0;
              end
            end else if (pix_ok) begin
              wr_row_r <= in_row_r; wr_col_r <= in_col_r;
              pix_mode_r <= 1'b1;
              state_r <= S_CHK;
              if (in_col_r + 1'b1 >= w_eff) begin
                in_col_r <= '0; in_row_r <= in_row_r + 1'b1;
                in_slot_r <= slot_inc(in_slot_r);
              end else begin
                in_col_r <= in_col_r + 1'b1;
              end
            end
          end
        end
        S_CHK: begin
          // set up window bounds if the next output is releasable
          if (!ovalid_r) begin
            if (out_row_r < h_eff && (!pix_mode_r || out_ready_now)) begin
              top_r <= (out_row_r > ROW_BITS'(hy_eff)) ? out_row_r - ROW_BITS'(hy_eff) : '0;
              bot_r <= (out_row_r + ROW_BITS'(hy_eff) < h_eff - 1'b1)
                       ? out_row_r + ROW_BITS'(hy_eff) : h_eff - 1'b1;
              left_r <= (out_col_r > WB'(hx_eff)) ? out_col_r - WB'(hx_eff) : '0;
              right_r <= rc;
              n_r <= '0; cidx_r <= '0;
              lo_found_r <= 1'b0;
              hi_found_r <= 1'b0;
              state_r <= S_EVAL;
              scan_done_r <= 1'b1;    // first pass only counts n
              cand_load_r <= 1'b1;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_EVAL: begin
          if (cand_load_r) begin
            cand_load_r <= 1'b0;
            n_r <= (CNTB'(bot_r - top_r) + 1'b1) * (CNTB'(right_r - left_r) + 1'b1);
            cv_r <= top_r; cu_r <= left_r; cidx_r <= '0;
            cslot_r <= (out_row_r > top_r)
              ? ((32'(out_slot_r) >= 32'(out_row_r - top_r))
                 ? RINGB'(32'(out_slot_r) - 32'(out_row_r - top_r))
                 : RINGB'(32'(out_slot_r) + RING - 32'(out_row_r - top_r)))
              : out_slot_r;
            state_r <= S_CAND;
          end else if (!rd_valid_r) begin
            // rank of candidate is final; keep it if it is one of the middles
            if (got_lo && got_hi) begin
              state_r <= S_OUT;
              res_r <= (PIXEL_BITS+1)'(lo_v) + (PIXEL_BITS+1)'(hi_v);
            end else begin
              if (less_cnt == k_lo) begin
                lo_val_r <= cand_r; lo_found_r <= 1'b1;
              end
              if (less_cnt == k_hi) begin
                hi_val_r <= cand_r; hi_found_r <= 1'b1;
              end
              state_r <= S_CAND;
              cidx_r <= cidx_r + 1'b1;
              if (cu_r == right_r) begin
                cu_r <= left_r; cv_r <= cv_r + 1'b1; cslot_r <= slot_inc(cslot_r);
              end else cu_r <= cu_r + 1'b1;
            end
          end
          rd_valid_r <= 1'b0;
        end
        S_CAND: begin
          // fetch candidate, then scan from top-left
          su_r <= left_r; sidx_r <= '0;
          sslot_r <= (cv_r > top_r)
            ? ((32'(cslot_r) >= 32'(cv_r - top_r))
               ? RINGB'(32'(cslot_r) - 32'(cv_r - top_r))
               : RINGB'(32'(cslot_r) + RING - 32'(cv_r - top_r)))
            : cslot_r;
          scan_done_r <= 1'b0;
          state_r <= S_SCAN;
          rd_valid_r <= 1'b0;
          cand_load_r <= 1'b0;
        end
        S_SCAN: begin
          if (!scan_done_r && sidx_r == '0 && !rd_valid_r && !cand_load_r) begin
            cand_r <= rd_data_r;   // candidate read data arrives now
            cand_load_r <= 1'b1;
          end
          if (!scan_done_r && (cand_load_r || sidx_r != '0 || rd_valid_r)) begin
            rd_valid_r <= 1'b1;
            rd_idx_r <= sidx_r;
            if (32'(sidx_r) + 1 == 32'(n_r)) scan_done_r <= 1'b1;
            else begin
              sidx_r <= sidx_r + 1'b1;
              if (su_r == right_r) begin
                su_r <= left_r; sslot_r <= slot_inc(sslot_r);
              end else su_r <= su_r + 1'b1;
            end
          end else if (scan_done_r) begin
            rd_valid_r <= 1'b0;
            cand_load_r <= 1'b0;
            state_r <= S_EVAL;
          end
        end
        S_OUT: begin
          ovalid_r <= 1'b1;
          last_r <= last_now;
          if (last_now) begin
            in_row_r <= '0; in_col_r <= '0; out_row_r <= '0; out_col_r <= '0;
            in_slot_r <= '0; out_slot_r <= '0;
            state_r <= S_IDLE;
          end else begin
            if (out_col_r + 1'b1 >= w_eff) begin
              out_col_r <= '0; out_row_r <= out_row_r + 1'b1;
              out_slot_r <= slot_inc(out_slot_r);
            end else out_col_r <= out_col_r + 1'b1;
            state_r <= pix_mode_r ? S_CHK : S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = ODW'(res_r);
  assign out_tlast  = last_r;

  // no new word enters while a result or a job is pending
  assert property (@(posedge clk) disable iff (!rst_n) in_tready |-> !ovalid_r)
    else $error("input taken while a result waits");
  assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_tready) |=> (ovalid_r && $stable(res_r)))
    else $error("result lost under stall");
  assert property (@(posedge clk) disable iff (!rst_n) state_r == S_OUT |-> !ovalid_r)
    else $error("result overwritten");
endmodule

// File: verif/clipped_window_median_filter_test.sv
// Self-checking testbench for the clipped window median filter.
module clipped_window_median_filter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cwmf_pkg::*;

  localparam int unsigned STORE_COLS = 1024;
  localparam int unsigned STORE_ROWS = 7;
  // Slowest output is a full 7x7 window.
  localparam int unsigned SETTLE_CYCLES = 3000;
  localparam int unsigned WATCHDOG_LIMIT = 40000;
  localparam int unsigned HOLD_OFF_CYCLES = 1500;

  typedef struct packed {
    logic [16:0] median;
    logic        last;
  } median_word_t;

  // One directed row: a register write or an input word, optionally with typed results.
  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_idx;
    int unsigned value;
    logic        cmd;
    int unsigned n_typed;
    logic [16:0] med0, med1;
    logic        last0, last1;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] pixel_value
  logic        in_tuser = 1'b0; // [0] cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [16:0] median_twice
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  clipped_window_median_filter dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the filter state.
  logic [15:0] line_mem [0:STORE_ROWS*STORE_COLS-1];
  int unsigned reg_w, reg_h, reg_hy, reg_hx;
  int unsigned in_row, in_col, out_row, out_col;

  median_word_t expected_q[$];
  median_word_t fresh_q[$];

  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned hold_left;
  int unsigned mismatches, words_in, words_out, cfg_writes;

  function automatic int unsigned eff_w();
    if (reg_w == 0) return 1;
    return (reg_w > 1024) ? 1024 : reg_w;
  endfunction

  function automatic int unsigned eff_h();
    if (reg_h == 0) return 1;
    return (reg_h > 4096) ? 4096 : reg_h;
  endfunction

  function automatic int unsigned median_twice(int unsigned y, int unsigned x);
    int unsigned top, bot, left, right, n;
    int unsigned win[$];
    top   = (y > reg_hy) ? y - reg_hy : 0;
    bot   = (y + reg_hy < eff_h() - 1) ? y + reg_hy : eff_h() - 1;
    left  = (x > reg_hx) ? x - reg_hx : 0;
    right = (x + reg_hx < eff_w() - 1) ? x + reg_hx : eff_w() - 1;
    for (int unsigned v = top; v <= bot; v++)
      for (int unsigned u = left; u <= right; u++)
        win.push_back(line_mem[(v % STORE_ROWS) * STORE_COLS + u]);
    win.sort();
    n = win.size();
    if (n % 2) return 2 * win[n/2];
    return win[n/2 - 1] + win[n/2];
  endfunction

  function automatic void restart_frame();
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
  endfunction

  function automatic void emit_median();
    median_word_t m;
    m.last = (out_row == eff_h() - 1) && (out_col == eff_w() - 1);
    m.median = 17'(median_twice(out_row, out_col));
    fresh_q.push_back(m);
    if (m.last) begin
      restart_frame();
      return;
    end
    out_col++;
    if (out_col >= eff_w()) begin
      out_col = 0;
      out_row++;
    end
  endfunction

  // Fill fresh_q with the medians that one accepted word releases.
  function automatic void predict_medians(logic cmd, logic [15:0] pix);
    int unsigned w, h, r, c, rc, k;
    bit ready;
    w = eff_w(); h = eff_h(); k = 0;
    fresh_q.delete();
    if (cmd == CMD_FLUSH) begin
      if (in_row >= h && out_row < h) emit_median();
      return;
    end
    if (in_row >= h || in_col >= w) return;
    r = in_row; c = in_col;
    line_mem[(r % STORE_ROWS) * STORE_COLS + c] = pix;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    while (k < 4 && out_row < h && (in_row != 0 || in_col != 0)) begin
      rc = (out_col + reg_hx < w - 1) ? out_col + reg_hx : w - 1;
      ready = (out_row + reg_hy < r) || (out_row + reg_hy == r && rc <= c);
      if (!ready) break;
      emit_median();
      k++;
      if (out_row == 0 && out_col == 0) break;
    end
  endfunction

  function automatic void apply_reg(logic [1:0] idx, int unsigned value);
    case (idx)
      REG_WIDTH:  reg_w  = value & 32'h7FF;
      REG_HEIGHT: reg_h  = value & 32'h1FFF;
      REG_HROWS:  reg_hy = value & 32'h3;
      REG_HCOLS:  reg_hx = value & 32'h3;
      default: ;
    endcase
    restart_frame();
  endfunction

  // Hold off until every expected median is out and the block has settled.
  task automatic drain();
    wait (expected_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_psel = 1'b1; cfg_penable = 1'b0; cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00}; cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    apply_reg(idx, value);
    cfg_writes++;
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned hy, int unsigned hx);
    drain();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_HROWS, hy);
    write_reg(REG_HCOLS, hx);
  endtask

  // Offer one word; leaves fresh_q holding the medians it released.
  task automatic send_word(logic cmd, logic [15:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1; in_tuser = cmd; in_tdata = pix;
    do @(posedge clk); while (!in_tready);
    words_in++;
    predict_medians(cmd, pix);
  endtask

  task automatic send_checked(logic cmd, logic [15:0] pix);
    send_word(cmd, pix);
    foreach (fresh_q[i]) expected_q.push_back(fresh_q[i]);
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  // Send one frame with some flush noise, then flush until it closes.
  task automatic send_frame(int unsigned n_pix);
    for (int unsigned i = 0; i < n_pix; i++) begin
      if ($urandom_range(99) < 8) send_checked(CMD_FLUSH, rand_pixel());
      send_checked(CMD_PIXEL, rand_pixel());
    end
    // a stray pixel past the last row is dropped
    if ($urandom_range(3) == 0 && in_row >= eff_h()) send_checked(CMD_PIXEL, rand_pixel());
    while (in_row != 0 || out_row != 0) send_checked(CMD_FLUSH, rand_pixel());
  endtask

  function automatic void set_idle(int unsigned mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      1: begin send_idle_pct = 75; recv_idle_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_idle_pct = 75; end
      default: begin send_idle_pct = 18; recv_idle_pct = 18; end
    endcase
  endfunction

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare every accepted median with the oldest expectation.
  always @(posedge clk) begin
    median_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      words_out++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected median word %0d last %0b", out_tdata[16:0], out_tlast);
      end else begin
        want = expected_q.pop_front();
        if (want.median !== out_tdata[16:0] || want.last !== out_tlast) begin
          mismatches++;
          if (mismatches <= 10)
            $display("median mismatch: expected %0d last %0b, got %0d last %0b",
                     want.median, want.last, out_tdata[16:0], out_tlast);
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake on any port.
  int unsigned quiet_cycles;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  stim_row_t table_rows[$];

  function automatic void add_cfg(logic [1:0] idx, int unsigned value);
    stim_row_t row;
    row = '{default: 0};
    row.is_cfg = 1; row.reg_idx = idx; row.value = value;
    table_rows.push_back(row);
  endfunction

  function automatic void add_word(logic cmd, int unsigned pix, int unsigned n,
                                   logic [16:0] m0 = 0, logic l0 = 0,
                                   logic [16:0] m1 = 0, logic l1 = 0);
    stim_row_t row;
    row = '{default: 0};
    row.cmd = cmd; row.value = pix; row.n_typed = n;
    row.med0 = m0; row.last0 = l0; row.med1 = m1; row.last1 = l1;
    table_rows.push_back(row);
  endfunction

  initial begin
    median_word_t typed;
    bit prev_item;
    reg_w = 1024; reg_h = 1024; reg_hy = 1; reg_hx = 1;
    restart_frame();
    hold_left = 0; mismatches = 0; words_in = 0; words_out = 0; cfg_writes = 0;
    quiet_cycles = 0;
    set_idle(0);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Single pixel frame: the median is the pixel itself, doubled.
    add_cfg(REG_WIDTH, 1); add_cfg(REG_HEIGHT, 1);
    add_cfg(REG_HROWS, 0); add_cfg(REG_HCOLS, 0);
    add_word(CMD_PIXEL, 16'hFFFF, 1, 17'd131070, 1);
    add_word(CMD_PIXEL, 16'h0000, 1, 17'd0, 1);
    add_word(CMD_FLUSH, 16'hFFFF, 0);                  // nothing pending
    // Zero width and zero height read as one.
    add_cfg(REG_WIDTH, 0);
    add_word(CMD_PIXEL, 16'h1234, 1, 17'h2468, 1);
    add_cfg(REG_HEIGHT, 0);
    add_word(CMD_PIXEL, 16'h8001, 1, 17'h10002, 1);
    // Two pixel row without and with horizontal reach.
    add_cfg(REG_WIDTH, 2);
    add_word(CMD_PIXEL, 3, 1, 17'd6, 0);
    add_word(CMD_PIXEL, 5, 1, 17'd10, 1);
    add_cfg(REG_HCOLS, 1);
    add_word(CMD_PIXEL, 3, 0);
    add_word(CMD_PIXEL, 4, 2, 17'd7, 0, 17'd7, 1);     // even window: sum of middles
    // 3x3 frame with maximal reach, drained by flushes.
    add_cfg(REG_WIDTH, 3); add_cfg(REG_HEIGHT, 3);
    add_cfg(REG_HROWS, 3); add_cfg(REG_HCOLS, 3);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) add_word(CMD_FLUSH, 0, 0);           // early flush is dropped
      add_word(CMD_PIXEL, (i * 7919) & 16'hFFFF, 0);
    end
    add_word(CMD_PIXEL, 16'hAAAA, 0);                  // past last row: dropped
    for (int i = 0; i < 9; i++) add_word(CMD_FLUSH, 16'h5555, 0);
    add_word(CMD_PIXEL, 16'h7777, 0);                  // starts a new frame

    prev_item = 0;
    foreach (table_rows[i]) begin
      if (table_rows[i].is_cfg) begin
        if (prev_item) begin
          end_burst();
          drain();
        end
        write_reg(table_rows[i].reg_idx, table_rows[i].value);
        prev_item = 0;
      end else begin
        send_word(table_rows[i].cmd, 16'(table_rows[i].value));
        if (table_rows[i].n_typed == 0) begin
          foreach (fresh_q[j]) expected_q.push_back(fresh_q[j]);
        end else begin
          typed.median = table_rows[i].med0; typed.last = table_rows[i].last0;
          expected_q.push_back(typed);
          if (table_rows[i].n_typed > 1) begin
            typed.median = table_rows[i].med1; typed.last = table_rows[i].last1;
            expected_q.push_back(typed);
          end
        end
        prev_item = 1;
      end
    end
    end_burst();

    // Random phases over several frame shapes, cycling the idle modes.
    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: set_frame(3, 3, 1, 1);
        1: set_frame(3, 3, 2, 0);
        2: set_frame(3, 2, 0, 2);
        3: set_frame(1, 6, 3, 3);
        4: set_frame(4, 2, 3, 3);
        5: set_frame(6, 8191, 1, 2);      // tall frame, left unfinished
        6: set_frame(2047, 1, 0, 3);      // widest row, left unfinished
        7: set_frame(2, 2, 1, 1);
        default: set_frame(3, 2, 3, 1);
      endcase
      set_idle(phase);
      if (phase == 1) hold_left = HOLD_OFF_CYCLES;  // let the block back up
      if (phase == 5 || phase == 6) begin
        for (int i = 0; i < 8; i++) send_checked(CMD_PIXEL, rand_pixel());
      end else begin
        send_frame(eff_w() * eff_h());
        if (phase == 2) begin
          end_burst();
          wait (expected_q.size() == 0);        // sender pauses until drained
          send_frame(eff_w() * eff_h());
        end
      end
      end_burst();
    end

    drain();
    $display("covered %0d input words, %0d medians, %0d register writes",
             words_in, words_out, cfg_writes);
    $display("frame shapes from 1x1 up to the start of a clamped 1024 pixel row, "
             , "reach 0 to 3, all idle modes");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/cwmf_pkg.sv
rtl/cwmf_rank.sv
rtl/clipped_window_median_filter.sv
verif/clipped_window_median_filter_test.sv
